### sv/ihdp_pkg.sv
// ----------------------------------------------------------------------------
// ihdp_pkg
// Shared types and constants for the image header dimension probe.
// ----------------------------------------------------------------------------
package ihdp_pkg;

    localparam int HEADER_CAPTURE = 26;
    localparam int MIN_HEADER     = 26;
    localparam int COUNT_W        = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    localparam logic [1:0] FMT_NONE = 2'd0;
    localparam logic [1:0] FMT_PNG  = 2'd1;
    localparam logic [1:0] FMT_BMP  = 2'd2;

    localparam logic [31:0] DIB_SIZE_INFO = 32'd40;
    localparam logic [31:0] DIB_SIZE_CORE = 32'd12;

    // Header kind as decided by the front end
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PNG   = 2'd1,
        KIND_BMP32 = 2'd2,
        KIND_BMP16 = 2'd3
    } kind_t;

    // One classified file, handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [31:0] width;
        logic [31:0] height;
    } job_t;

endpackage

### sv/ihdp_front.sv
// ----------------------------------------------------------------------------
// ihdp_front
// Captures header bytes, counts bytes, and classifies the file on its last byte.
// ----------------------------------------------------------------------------
module ihdp_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_data_byte,
    input  logic           s_last_byte,
    input  logic           q_full,
    output logic           push,
    output ihdp_pkg::job_t push_job
);
    import ihdp_pkg::*;

    logic [7:0]         hdr_reg  [HEADER_CAPTURE];
    logic [7:0]         hdr_next [HEADER_CAPTURE];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               accept;
    logic               is_png_sig;
    logic               is_ihdr;
    logic               is_bm;
    logic [31:0]        dib_size;
    logic               too_short;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && s_last_byte;

    // Merge the incoming byte into its slot
    always_comb begin
        for (int i = 0; i < HEADER_CAPTURE; i++) begin
            hdr_next[i] = (count_reg == COUNT_W'(i)) ? s_data_byte : hdr_reg[i];
        end
    end

    assign count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign too_short  = count_next < COUNT_W'(MIN_HEADER);

    assign is_png_sig = hdr_next[0] == 8'h89 && hdr_next[1] == 8'h50 &&
                        hdr_next[2] == 8'h4E && hdr_next[3] == 8'h47 &&
                        hdr_next[4] == 8'h0D && hdr_next[5] == 8'h0A &&
                        hdr_next[6] == 8'h1A && hdr_next[7] == 8'h0A;
    assign is_ihdr    = hdr_next[12] == 8'h49 && hdr_next[13] == 8'h48 &&
                        hdr_next[14] == 8'h44 && hdr_next[15] == 8'h52;
    assign is_bm      = hdr_next[0] == 8'h42 && hdr_next[1] == 8'h4D;
    assign dib_size   = {hdr_next[17], hdr_next[16], hdr_next[15], hdr_next[14]};

    always_comb begin
        push_job.kind   = KIND_NONE;
        push_job.width  = '0;
        push_job.height = '0;
        if (too_short) begin
            push_job.kind = KIND_NONE;
        end else if (is_png_sig) begin
            if (is_ihdr) begin
                push_job.kind   = KIND_PNG;
                push_job.width  = {hdr_next[16], hdr_next[17], hdr_next[18], hdr_next[19]};
                push_job.height = {hdr_next[20], hdr_next[21], hdr_next[22], hdr_next[23]};
            end
        end else if (is_bm) begin
            if (dib_size >= DIB_SIZE_INFO) begin
                push_job.kind   = KIND_BMP32;
                push_job.width  = {hdr_next[21], hdr_next[20], hdr_next[19], hdr_next[18]};
                push_job.height = {hdr_next[25], hdr_next[24], hdr_next[23], hdr_next[22]};
            end else if (dib_size == DIB_SIZE_CORE) begin
                push_job.kind   = KIND_BMP16;
                push_job.width  = {16'h0000, hdr_next[19], hdr_next[18]};
                push_job.height = {16'h0000, hdr_next[21], hdr_next[20]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= s_last_byte ? '0 : count_next;
        end
    end

    // Stale bytes after a file end are never read before being rewritten
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < HEADER_CAPTURE; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule

### sv/ihdp_queue.sv
// ----------------------------------------------------------------------------
// ihdp_queue
// Two-entry queue of classified files between front and back.
// ----------------------------------------------------------------------------
module ihdp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ihdp_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output ihdp_pkg::job_t head_job
);
    import ihdp_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_pop;

    assign full       = fill_reg == 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, do_pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/ihdp_back.sv
// ----------------------------------------------------------------------------
// ihdp_back
// Checks BMP dimensions and holds the result in the output register.
// ----------------------------------------------------------------------------
module ihdp_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  ihdp_pkg::job_t head_job,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_recognized,
    output logic [1:0]     m_image_format,
    output logic [31:0]    m_image_width,
    output logic [31:0]    m_image_height
);
    import ihdp_pkg::*;

    logic        valid_reg;
    logic        rec_next;
    logic [1:0]  fmt_next;
    logic [31:0] width_next;
    logic [31:0] height_next;
    logic [31:0] abs_height;
    logic        bad_dim;

    assign pop     = head_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;

    assign abs_height = (head_job.kind == KIND_BMP32 && head_job.height[31]) ?
                        (32'd0 - head_job.height) : head_job.height;
    assign bad_dim    = head_job.width == '0 || head_job.width[31] ||
                        abs_height == '0 || abs_height[31];

    always_comb begin
        rec_next    = 1'b0;
        fmt_next    = FMT_NONE;
        width_next  = '0;
        height_next = '0;
        case (head_job.kind)
            KIND_PNG: begin
                rec_next    = 1'b1;
                fmt_next    = FMT_PNG;
                width_next  = head_job.width;
                height_next = head_job.height;
            end
            KIND_BMP32, KIND_BMP16: begin
                if (!bad_dim) begin
                    rec_next    = 1'b1;
                    fmt_next    = FMT_BMP;
                    width_next  = head_job.width;
                    height_next = abs_height;
                end
            end
            default: begin
                rec_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_recognized   <= rec_next;
            m_image_format <= fmt_next;
            m_image_width  <= width_next;
            m_image_height <= height_next;
        end
    end

endmodule

### sv/image_header_dimension_probe.sv
// ----------------------------------------------------------------------------
// image_header_dimension_probe
// Streams a file byte by byte and reports PNG/BMP format and image size.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full; s_ready drops when it is.
// Result path: the edge that takes the last byte's request writes a queue slot;
//   the output register is loaded from that slot when the back pops it (output
//   register empty or being taken), and m_valid rises with that load.
// Reset: aresetn clears the byte count, empties the queue and drops m_valid;
//   captured header bytes are left as they are and rewritten by the next file.
module image_header_dimension_probe (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_recognized,
    output logic [1:0]  m_image_format,
    output logic [31:0] m_image_width,
    output logic [31:0] m_image_height
);
    import ihdp_pkg::*;

    // Front to queue: one classified file per request with the last byte
    logic q_full;
    logic push;
    job_t push_job;

    // Queue to back
    logic head_valid;
    logic pop;
    job_t head_job;

    // Capture bytes, count them, and classify the header on the last byte.
    // The front stalls only when the queue is full.
    ihdp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    // Hold classified files so a stalled result port stops the byte stream only once the queue is full
    ihdp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Negate a negative BMP height, reject bad dimensions, and register the result request
    ihdp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_job       (head_job),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_recognized   (m_recognized),
        .m_image_format (m_image_format),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height)
    );

endmodule
